FILE: hw/rtl/stl_pkg.sv
// stl_pkg: types, token kinds and keyword table for the source token lexer
// depends on nothing; used by all lexer modules
package stl_pkg;

	localparam logic [15:0] Sat16 = 16'hFFFF;

	localparam logic [5:0] KIND_UNKNOWN = 6'd0;
	localparam logic [5:0] KIND_EOF     = 6'd1;
	localparam logic [5:0] KIND_IDENT   = 6'd2;
	localparam logic [5:0] KIND_NUMBER  = 6'd3;
	localparam logic [5:0] KIND_STRING  = 6'd4;
	localparam logic [5:0] KIND_EQ      = 6'd5;
	localparam logic [5:0] KIND_EQEQ    = 6'd6;
	localparam logic [5:0] KIND_SPECIAL = 6'd7;
	localparam logic [5:0] KIND_KEYWORD = 6'd23;

	typedef enum logic [5:0] {
		MODE_IDLE   = 6'b000001,
		MODE_IDENT  = 6'b000010,
		MODE_NUMBER = 6'b000100,
		MODE_STRING = 6'b001000,
		MODE_EQUALS = 6'b010000,
		MODE_HALT   = 6'b100000
	} mode_t;

	// one token as it travels through the queue
	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [15:0] line;
		logic        last;
	} token_t;

	// front to queue: up to two tokens caused by one byte
	typedef struct packed {
		logic   valid0;
		logic   valid1;
		token_t tok0;
		token_t tok1;
	} tok_pair_t;

	localparam int unsigned NumKw = 15;

	// keywords right-aligned, eight bits per letter, first letter highest
	function automatic logic [63:0] kw_text(input logic [3:0] idx);
		logic [63:0] t;
		unique case (idx)
			4'd0:  t = 64'h766172;
			4'd1:  t = 64'h636f6e7374;
			4'd2:  t = 64'h74727565;
			4'd3:  t = 64'h66616c7365;
			4'd4:  t = 64'h6966;
			4'd5:  t = 64'h656c7365;
			4'd6:  t = 64'h7768696c65;
			4'd7:  t = 64'h616e64;
			4'd8:  t = 64'h6f72;
			4'd9:  t = 64'h66756e;
			4'd10: t = 64'h737472696e67;
			4'd11: t = 64'h696e74;
			4'd12: t = 64'h626f6f6c;
			4'd13: t = 64'h766f6964;
			4'd14: t = 64'h72657475726e;
			default: t = 64'h0;
		endcase
		return t;
	endfunction

	function automatic logic [3:0] kw_len(input logic [3:0] idx);
		logic [3:0] l;
		unique case (idx) inside
			4'd0, 4'd7, 4'd9, 4'd11:          l = 4'd3;
			4'd1, 4'd3, 4'd6:                 l = 4'd5;
			4'd2, 4'd5, 4'd12, 4'd13:         l = 4'd4;
			4'd4, 4'd8:                       l = 4'd2;
			4'd10, 4'd14:                     l = 4'd6;
			default:                          l = 4'd0;
		endcase
		return l;
	endfunction

	// special character code, 16 when the byte is not one
	function automatic logic [4:0] special_idx(input logic [7:0] b);
		logic [4:0] r;
		unique case (b)
			8'h2b: r = 5'd0;
			8'h2d: r = 5'd1;
			8'h2a: r = 5'd2;
			8'h2f: r = 5'd3;
			8'h25: r = 5'd4;
			8'h28: r = 5'd5;
			8'h29: r = 5'd6;
			8'h2c: r = 5'd7;
			8'h3c: r = 5'd8;
			8'h3e: r = 5'd9;
			8'h26: r = 5'd10;
			8'h7c: r = 5'd11;
			8'h7b: r = 5'd12;
			8'h7d: r = 5'd13;
			8'h21: r = 5'd14;
			8'h3a: r = 5'd15;
			default: r = 5'd16;
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/stl_front.sv
// stl_front: byte classifier and lexer state, produces up to two tokens per byte
// depends on stl_pkg
module stl_front #(
	parameter int unsigned MAX_SOURCE    = 65536,
	parameter int unsigned KEYWORD_CHARS = 6
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	input  logic [7:0]          byte_data,
	input  logic                room,
	output stl_pkg::tok_pair_t  pair
);

	localparam int unsigned PfxW = 8 * KEYWORD_CHARS;
	localparam logic [15:0] PosLim = (MAX_SOURCE - 1 > 65535) ? 16'hFFFF
		: 16'(MAX_SOURCE - 1);

	stl_pkg::mode_t mode_q, mode_d;
	logic [15:0] pstart_q, pstart_d, plen_q, plen_d, line_q, line_d, pos_q, pos_d;
	logic [PfxW-1:0] pfx_q, pfx_d;

	logic byte_take;
	logic is_letter, is_digit;
	logic [4:0] sp;
	logic [5:0] id_kind;
	logic [15:0] pos_inc, plen_inc, line_inc;
	logic lex_now;

	assign byte_take = byte_valid && room;
	assign is_letter = (byte_data >= 8'h61 && byte_data <= 8'h7a)
		|| (byte_data >= 8'h41 && byte_data <= 8'h5a);
	assign is_digit = byte_data >= 8'h30 && byte_data <= 8'h39;
	assign sp = stl_pkg::special_idx(byte_data);
	assign pos_inc = (pos_q >= PosLim) ? PosLim : pos_q + 16'd1;
	assign plen_inc = (plen_q == stl_pkg::Sat16) ? plen_q : plen_q + 16'd1;
	assign line_inc = (line_q == stl_pkg::Sat16) ? line_q : line_q + 16'd1;

	// whole-token keyword compare, in parallel
	always_comb begin
		logic [63:0] wide;
		wide = 64'(pfx_q);
		id_kind = stl_pkg::KIND_IDENT;
		if (plen_q <= 16'(KEYWORD_CHARS)) begin
			for (int k = 0; k < stl_pkg::NumKw; k++) begin
				if (16'(stl_pkg::kw_len(4'(k))) == plen_q
						&& stl_pkg::kw_text(4'(k)) == wide)
					id_kind = stl_pkg::KIND_KEYWORD + 6'(k);
			end
		end
	end

	always_comb begin
		stl_pkg::token_t t0, t1;
		logic v0, v1;
		mode_d = mode_q; pstart_d = pstart_q; plen_d = plen_q;
		line_d = line_q; pos_d = pos_q; pfx_d = pfx_q;
		v0 = 1'b0; v1 = 1'b0;
		t0 = '0; t1 = '0;
		lex_now = 1'b0;
		t0.line = line_q; t1.line = line_q;
		unique case (mode_q)
			stl_pkg::MODE_HALT: begin
				if (byte_data == 8'h00) begin
					mode_d = stl_pkg::MODE_IDLE; pstart_d = '0; plen_d = '0;
					line_d = 16'd1; pos_d = '0; pfx_d = '0;
				end else pos_d = pos_inc;
			end
			stl_pkg::MODE_STRING: begin
				if (byte_data == 8'h22) begin
					v0 = 1'b1; t0.kind = stl_pkg::KIND_STRING; t0.start = pstart_q;
					t0.length = plen_inc; mode_d = stl_pkg::MODE_IDLE; pos_d = pos_inc;
				end else if (byte_data == 8'h00) begin
					v0 = 1'b1; t0.kind = stl_pkg::KIND_UNKNOWN; t0.start = pstart_q;
					t0.length = 16'd1;
					mode_d = stl_pkg::MODE_IDLE; pstart_d = '0; plen_d = '0;
					line_d = 16'd1; pos_d = '0; pfx_d = '0;
				end else if (byte_data == 8'h0a) begin
					v0 = 1'b1; t0.kind = stl_pkg::KIND_UNKNOWN; t0.start = pstart_q;
					t0.length = 16'd1; mode_d = stl_pkg::MODE_HALT; pos_d = pos_inc;
				end else begin
					plen_d = plen_inc; pos_d = pos_inc;
				end
			end
			stl_pkg::MODE_IDENT: begin
				if (is_letter) begin
					if (plen_q < 16'(KEYWORD_CHARS))
						pfx_d = {pfx_q[PfxW-9:0], byte_data};
					plen_d = plen_inc; pos_d = pos_inc;
				end else begin
					v0 = 1'b1; t0.kind = id_kind; t0.start = pstart_q;
					t0.length = plen_q; lex_now = 1'b1;
				end
			end
			stl_pkg::MODE_NUMBER: begin
				if (is_digit) begin
					plen_d = plen_inc; pos_d = pos_inc;
				end else begin
					v0 = 1'b1; t0.kind = stl_pkg::KIND_NUMBER; t0.start = pstart_q;
					t0.length = plen_q; lex_now = 1'b1;
				end
			end
			stl_pkg::MODE_EQUALS: begin
				v0 = 1'b1; t0.start = pstart_q; mode_d = stl_pkg::MODE_IDLE;
				if (byte_data == 8'h3d) begin
					t0.kind = stl_pkg::KIND_EQEQ; t0.length = 16'd2; pos_d = pos_inc;
				end else begin
					t0.kind = stl_pkg::KIND_EQ; t0.length = 16'd1; lex_now = 1'b1;
				end
			end
			default: lex_now = 1'b1;
		endcase

		if (lex_now) begin
			mode_d = stl_pkg::MODE_IDLE;
			t1.start = pos_q; t1.length = 16'd1;
			if (byte_data == 8'h00) begin
				v1 = 1'b1; t1.kind = stl_pkg::KIND_EOF; t1.length = '0;
				pstart_d = '0; plen_d = '0; line_d = 16'd1; pos_d = '0; pfx_d = '0;
			end else begin
				pos_d = pos_inc;
				if (byte_data == 8'h0a) line_d = line_inc;
				else if (byte_data == 8'h20 || byte_data == 8'h09) begin
				end else if (byte_data == 8'h22) begin
					mode_d = stl_pkg::MODE_STRING; pstart_d = pos_q; plen_d = 16'd1;
				end else if (byte_data == 8'h3d) begin
					mode_d = stl_pkg::MODE_EQUALS; pstart_d = pos_q; plen_d = 16'd1;
				end else if (is_letter) begin
					mode_d = stl_pkg::MODE_IDENT; pstart_d = pos_q; plen_d = 16'd1;
					pfx_d = PfxW'(byte_data);
				end else if (is_digit) begin
					mode_d = stl_pkg::MODE_NUMBER; pstart_d = pos_q; plen_d = 16'd1;
				end else if (sp != 5'd16) begin
					v1 = 1'b1; t1.kind = stl_pkg::KIND_SPECIAL + 6'(sp);
				end else begin
					v1 = 1'b1; t1.kind = stl_pkg::KIND_UNKNOWN;
					mode_d = stl_pkg::MODE_HALT;
				end
			end
		end
		t1.last = v1;
		t0.last = !v1;
		// pack so the first valid token sits in slot 0
		if (!v0 && v1) begin
			pair.valid0 = 1'b1; pair.valid1 = 1'b0; pair.tok0 = t1; pair.tok1 = t1;
		end else begin
			pair.valid0 = v0; pair.valid1 = v1; pair.tok0 = t0; pair.tok1 = t1;
		end
		if (!byte_take) begin
			pair.valid0 = 1'b0; pair.valid1 = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stl_pkg::MODE_IDLE;
			pstart_q <= '0; plen_q <= '0; line_q <= 16'd1; pos_q <= '0; pfx_q <= '0;
		end else if (byte_take) begin
			mode_q <= mode_d; pstart_q <= pstart_d; plen_q <= plen_d;
			line_q <= line_d; pos_q <= pos_d; pfx_q <= pfx_d;
		end
	end

endmodule

FILE: hw/rtl/stl_queue.sv
// stl_queue: four-entry token queue, two writes and one read per cycle
// depends on stl_pkg
module stl_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  stl_pkg::tok_pair_t  pair,
	output logic                room,
	output logic                tok_valid,
	output stl_pkg::token_t     tok,
	input  logic                tok_pop
);

	stl_pkg::token_t mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic [1:0] nw;
	logic pop;

	assign room = cnt_q <= 3'd2;
	assign tok_valid = cnt_q != 3'd0;
	assign tok = mem_q[rd_q];
	assign pop = tok_valid && tok_pop;
	assign nw = {1'b0, pair.valid0} + {1'b0, pair.valid1};

	always_ff @(posedge clk) begin
		if (pair.valid0) mem_q[wr_q] <= pair.tok0;
		if (pair.valid1) mem_q[wr_q + 2'd1] <= pair.tok1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			wr_q <= wr_q + nw;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + 3'(nw) - 3'(pop);
		end
	end

endmodule

FILE: hw/rtl/stl_back.sv
// stl_back: output register stage driving the token channel
// depends on stl_pkg
module stl_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tok_valid,
	input  stl_pkg::token_t  tok,
	output logic             tok_pop,
	output logic             out_valid,
	output stl_pkg::token_t  out_tok,
	input  logic             out_stall
);

	logic load;
	assign load = !out_valid || !out_stall;
	assign tok_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (load) out_valid <= tok_valid;
	end

	always_ff @(posedge clk) begin
		if (load) out_tok <= tok;
	end

endmodule

FILE: hw/rtl/source_token_lexer.sv
// source_token_lexer: streaming lexer top level
// depends on stl_pkg, stl_front, stl_queue, stl_back
//
// channel   direction  handshake           payload
// source    in         valid / stall       source_byte
// token     out        token_valid / stall token_kind/start/length/line, last_of_run
//
// one byte per cycle sustained while the token side does not stall; a byte that
// causes two tokens sends them out one after the other, so a long run of such
// bytes paces at the token port; the front keeps all lexer state and takes a byte
// whenever the queue has room for two tokens; tokens are queued, then registered
// reset clears mode, counters and queue; line counter restarts at one
// stall on the token side fills the queue, then raises stall on the source
module source_token_lexer #(
	parameter int unsigned MAX_SOURCE    = 65536,
	parameter int unsigned KEYWORD_CHARS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  logic [7:0]  source_byte,
	output logic        token_valid,
	input  logic        token_stall,
	output logic [5:0]  token_kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic [15:0] token_line,
	output logic        last_of_run
);

	stl_pkg::tok_pair_t pair;
	stl_pkg::token_t q_tok, o_tok;
	logic room, q_valid, q_pop;

	// front: classify and update state
	stl_front #(.MAX_SOURCE(MAX_SOURCE), .KEYWORD_CHARS(KEYWORD_CHARS)) u_front (
		.clk(clk), .arst_n(arst_n), .byte_valid(valid), .byte_data(source_byte),
		.room(room), .pair(pair)
	);

	// queue decouples the two sides
	stl_queue u_queue (
		.clk(clk), .arst_n(arst_n), .pair(pair), .room(room),
		.tok_valid(q_valid), .tok(q_tok), .tok_pop(q_pop)
	);

	stl_back u_back (
		.clk(clk), .arst_n(arst_n), .tok_valid(q_valid), .tok(q_tok),
		.tok_pop(q_pop), .out_valid(token_valid), .out_tok(o_tok),
		.out_stall(token_stall)
	);

	assign stall = !room;
	assign token_kind = o_tok.kind;
	assign token_start = o_tok.start;
	assign token_length = o_tok.length;
	assign token_line = o_tok.line;
	assign last_of_run = o_tok.last;

endmodule

FILE: hw/rtl/stl_checker.sv
// stl_checker: port-level assertions for the lexer, bound to the top level
// depends on stl_pkg and source_token_lexer ports only
module stl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        token_valid,
	input logic        token_stall,
	input logic [5:0]  token_kind,
	input logic [15:0] token_length,
	input logic [15:0] token_line,
	input logic        last_of_run
);

	localparam logic [5:0] KindMax = stl_pkg::KIND_KEYWORD + 6'(stl_pkg::NumKw - 1);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> token_valid && $stable(token_kind))
		else $error("stalled token changed");
	a_eof_len: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_kind == stl_pkg::KIND_EOF
		|-> token_length == 16'd0 && last_of_run)
		else $error("bad eof");
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid |-> token_kind <= KindMax && token_line != 16'd0)
		else $error("bad kind or line");
	a_eqeq: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_kind == stl_pkg::KIND_EQEQ |-> token_length == 16'd2)
		else $error("bad double equals");

endmodule

bind source_token_lexer stl_checker u_stl_checker (
	.clk(clk), .arst_n(arst_n),
	.token_valid(token_valid), .token_stall(token_stall), .token_kind(token_kind),
	.token_length(token_length), .token_line(token_line), .last_of_run(last_of_run)
);
